FILE: sv/lfu_pkg.sv
// Package with the payload types and constants of the LFU cache table.
`default_nettype none
package lfu_pkg;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] lookup_key;
    logic [63:0] write_data;
    logic [63:0] expected_data;
  } lfu_req_t;

  typedef struct packed {
    logic        key_found;
    logic [63:0] read_data;
    logic        data_matched;
    logic        did_evict;
    logic [31:0] victim_key;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } lfu_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // load request, clear scan results
    logic scan;      // examine entry at scan index
    logic evict;     // remove the chosen victim
    logic find_free; // restart the scan looking for a free slot
    logic commit;    // apply the access and form the result
  } lfu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic need_evict;
    logic is_insert;
  } lfu_sts_t;

endpackage
`default_nettype wire

FILE: sv/lfu_datapath.sv
// Datapath of the LFU cache table: entry store, scan registers and counters.
`default_nettype none
module lfu_datapath
  import lfu_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int COUNT_BITS    = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            cfg_we_i,
  input  wire [4:0]      cfg_data_i,
  input  lfu_req_t       req_i,
  input  lfu_cmd_t       cmd_i,
  output lfu_sts_t       sts_o,
  output lfu_rsp_t       rsp_o
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int NW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [NW-1:0] EntriesN = NW'(TABLE_ENTRIES);

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [31:0]           key_q   [TABLE_ENTRIES];
  logic [63:0]           value_q [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] count_q [TABLE_ENTRIES];
  logic [31:0]           stamp_q [TABLE_ENTRIES];

  logic [31:0]   clock_q;
  logic [NW-1:0] used_q;
  logic [31:0]   hits_q, misses_q;
  logic [4:0]    cap_q;
  lfu_req_t      req_q;
  lfu_rsp_t      rsp_q;

  logic [IW-1:0] idx_q;
  logic          found_q, vic_ok_q, free_ok_q, evicted_q;
  logic [IW-1:0] hit_idx_q, vic_idx_q, free_idx_q;
  logic [COUNT_BITS-1:0] vic_cnt_q;
  logic [31:0]   vic_age_q, vkey_q;

  // Effective capacity: zero counts as one, large values saturate.
  logic [NW-1:0] cap_eff;
  always_comb begin
    if (cap_q == 5'd0) begin
      cap_eff = NW'(1);
    end else if ({27'd0, cap_q} > 32'(TABLE_ENTRIES)) begin
      cap_eff = EntriesN;
    end else begin
      cap_eff = NW'(cap_q);
    end
  end

  // Entry under the scan index.
  logic [31:0] age;
  logic        better;
  assign age = clock_q - stamp_q[idx_q];
  assign better = valid_q[idx_q] && (!vic_ok_q || count_q[idx_q] < vic_cnt_q ||
                  (count_q[idx_q] == vic_cnt_q && age > vic_age_q));

  assign sts_o.scan_last  = (32'(idx_q) == TABLE_ENTRIES - 1);
  assign sts_o.is_insert  = (req_q.command == CMD_WRITE) && !found_q;
  assign sts_o.need_evict = vic_ok_q && (used_q >= cap_eff);
  assign rsp_o = rsp_q;

  // Result of the access being committed.
  lfu_rsp_t rsp_d;
  always_comb begin
    rsp_d.key_found    = found_q;
    rsp_d.read_data    = '0;
    rsp_d.data_matched = 1'b0;
    rsp_d.did_evict    = evicted_q;
    rsp_d.victim_key   = evicted_q ? vkey_q : 32'd0;
    rsp_d.hit_total    = hits_q;
    rsp_d.miss_total   = misses_q;
    if (req_q.command == CMD_READ) begin
      if (found_q) begin
        rsp_d.read_data = value_q[hit_idx_q];
        if (value_q[hit_idx_q] == req_q.expected_data) begin
          rsp_d.data_matched = 1'b1;
          rsp_d.hit_total    = (hits_q != '1) ? hits_q + 1'b1 : hits_q;
        end else begin
          rsp_d.miss_total = (misses_q != '1) ? misses_q + 1'b1 : misses_q;
        end
      end else begin
        rsp_d.read_data  = '1;
        rsp_d.miss_total = (misses_q != '1) ? misses_q + 1'b1 : misses_q;
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 5'd16;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Scan registers and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      clock_q   <= '0;
      used_q    <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
      idx_q     <= '0;
      found_q   <= 1'b0;
      vic_ok_q  <= 1'b0;
      free_ok_q <= 1'b0;
      evicted_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        idx_q     <= '0;
        found_q   <= 1'b0;
        vic_ok_q  <= 1'b0;
        free_ok_q <= 1'b0;
        evicted_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
        if (valid_q[idx_q] && key_q[idx_q] == req_q.lookup_key && !found_q) begin
          found_q <= 1'b1;
        end
        if (better) begin
          vic_ok_q <= 1'b1;
        end
        if (!valid_q[idx_q] && !free_ok_q) begin
          free_ok_q <= 1'b1;
        end
      end
      if (cmd_i.evict) begin
        valid_q[vic_idx_q] <= 1'b0;
        used_q    <= used_q - 1'b1;
        evicted_q <= 1'b1;
      end
      if (cmd_i.find_free) begin
        idx_q     <= '0;
        free_ok_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        if (req_q.command == CMD_READ) begin
          if (found_q) begin
            clock_q <= clock_q + 1'b1;
            if (value_q[hit_idx_q] == req_q.expected_data) begin
              if (hits_q != '1) hits_q <= hits_q + 1'b1;
            end else if (misses_q != '1) begin
              misses_q <= misses_q + 1'b1;
            end
          end else if (misses_q != '1) begin
            misses_q <= misses_q + 1'b1;
          end
        end else if (found_q) begin
          clock_q <= clock_q + 1'b1;
        end else if (free_ok_q) begin
          valid_q[free_idx_q] <= 1'b1;
          clock_q <= clock_q + 1'b1;
          used_q  <= used_q + 1'b1;
        end
      end
    end
  end

  // Payload registers: request, scan picks, entry store and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= req_i;
    end
    if (cmd_i.scan) begin
      if (valid_q[idx_q] && key_q[idx_q] == req_q.lookup_key && !found_q) begin
        hit_idx_q <= idx_q;
      end
      if (better) begin
        vic_idx_q <= idx_q;
        vic_cnt_q <= count_q[idx_q];
        vic_age_q <= age;
        vkey_q    <= key_q[idx_q];
      end
      if (!valid_q[idx_q] && !free_ok_q) begin
        free_idx_q <= idx_q;
      end
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
      if (req_q.command == CMD_READ) begin
        if (found_q) begin
          if (count_q[hit_idx_q] != CountMax) count_q[hit_idx_q] <= count_q[hit_idx_q] + 1'b1;
          stamp_q[hit_idx_q] <= clock_q;
        end
      end else if (found_q) begin
        value_q[hit_idx_q] <= req_q.write_data;
        if (count_q[hit_idx_q] != CountMax) count_q[hit_idx_q] <= count_q[hit_idx_q] + 1'b1;
        stamp_q[hit_idx_q] <= clock_q;
      end else if (free_ok_q) begin
        key_q[free_idx_q]   <= req_q.lookup_key;
        value_q[free_idx_q] <= req_q.write_data;
        count_q[free_idx_q] <= COUNT_BITS'(1);
        stamp_q[free_idx_q] <= clock_q;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/lfu_ctrl.sv
// Controller of the LFU cache table: sequences scan, eviction and commit.
`default_nettype none
module lfu_ctrl
  import lfu_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  wire      out_stall,
  input  lfu_sts_t sts_i,
  output lfu_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_FREE, ST_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // A new transfer may start once any waiting result is taken this cycle.
  logic out_free;
  assign out_free  = !out_valid_q || !out_stall;
  assign in_stall  = !(state_q == ST_IDLE && out_free);
  assign out_valid = out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:   cmd_o.start = in_valid && out_free;
      ST_SCAN:   cmd_o.scan = 1'b1;
      ST_DECIDE: begin
        cmd_o.evict     = sts_i.is_insert && sts_i.need_evict;
        cmd_o.find_free = sts_i.is_insert && sts_i.need_evict;
      end
      ST_FREE:   cmd_o.scan = 1'b1;
      ST_COMMIT: cmd_o.commit = out_free;
      default:   cmd_o = '0;
    endcase
  end

  // State and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_COMMIT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE:   if (in_valid && out_free) state_q <= ST_SCAN;
        ST_SCAN:   if (sts_i.scan_last) state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (sts_i.is_insert && sts_i.need_evict) state_q <= ST_FREE;
          else state_q <= ST_COMMIT;
        end
        ST_FREE:   if (sts_i.scan_last) state_q <= ST_COMMIT;
        ST_COMMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/lfu_cache_table.sv
// Top level of the LFU cache table: controller, datapath and checks.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_data_i  (lfu_req_t)
// out      output     out_valid / out_stall out_data_o (lfu_rsp_t)
// cfg      input      cfg_we_i              cfg_data_i (capacity_in_use)
//
// A transfer makes one pass over the entries for a hit, a miss or a fill, and two
// passes when a write evicts: the first pass finds key and victim, and an eviction
// is followed by a second pass for the freed slot.
// Reset clears all valid bits at once, so no clearing pass is needed.
// A stalled result holds in the output register; the next request waits for it.
`default_nettype none
module lfu_cache_table
  import lfu_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int COUNT_BITS    = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       cfg_we_i,
  input  wire [4:0] cfg_data_i,
  input  wire       in_valid,
  output logic      in_stall,
  input  lfu_req_t  in_data_i,
  output logic      out_valid,
  input  wire       out_stall,
  output lfu_rsp_t  out_data_o
);

  lfu_cmd_t cmd;
  lfu_sts_t sts;

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts_i(sts), .cmd_o(cmd)
  );

  lfu_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

  // A result is only produced by a commit.
  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result raised without commit");

  // No new request is taken while a result is pending and stalled.
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |-> in_stall)
    else $error("request taken over stalled result");

  // An eviction is only reported when the key was not found.
  a_evict_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data_o.did_evict) |-> !out_data_o.key_found)
    else $error("eviction on a present key");

endmodule
`default_nettype wire
